// ===== hw/rtl/rfct_pkg.sv =====
// Shared types and constants for the range flip / count-ones tree.
package rfct_pkg;

    localparam int unsigned IDX_W   = 10;
    localparam int unsigned COUNT_W = 11;

    localparam logic FUNC_FLIP  = 1'b0;
    localparam logic FUNC_COUNT = 1'b1;

    typedef enum logic [9:0] {
        ST_CLEAR = 10'b0000000001,
        ST_IDLE  = 10'b0000000010,
        ST_RD    = 10'b0000000100,
        ST_CHK   = 10'b0000001000,
        ST_RET   = 10'b0000010000,
        ST_PL    = 10'b0000100000,
        ST_PR    = 10'b0001000000,
        ST_PP    = 10'b0010000000,
        ST_PW    = 10'b0100000000,
        ST_DONE  = 10'b1000000000
    } walk_state_t;

    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] count;
    } res_t;

endpackage

// ===== hw/rtl/rfct_mem.sv =====
// Node store: one write port, one read port with registered read data.
module rfct_mem #(
    parameter int unsigned AW = 11,
    parameter int unsigned DW = 12
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/rfct_walk.sv =====
// Tree walk sequencer: depth-first visit of the node store with read-modify-write.
module rfct_walk #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    output logic                          idle,
    input  logic                          func,
    input  logic [rfct_pkg::IDX_W-1:0]    range_start,
    input  logic [rfct_pkg::IDX_W-1:0]    range_end,
    output rfct_pkg::res_t                res,
    input  logic                          res_ready,
    output logic                          mem_we,
    output logic [$clog2(LEAVES):0]       mem_waddr,
    output logic [$clog2(LEAVES)+1:0]     mem_wdata,
    output logic [$clog2(LEAVES):0]       mem_raddr,
    input  logic [$clog2(LEAVES)+1:0]     mem_rdata
);

    localparam int unsigned L   = $clog2(LEAVES);
    localparam int unsigned NW  = L + 1;
    localparam int unsigned DPW = $clog2(L + 1);
    localparam int unsigned CW  = L + 1;
    localparam int unsigned IW  = (L > rfct_pkg::IDX_W) ? L : rfct_pkg::IDX_W;
    localparam int unsigned ACW = (CW > rfct_pkg::COUNT_W) ? CW : rfct_pkg::COUNT_W;
    localparam logic [IW-1:0]  LAST   = IW'(LEAVES - 1);
    localparam logic [DPW-1:0] DEPTH0 = '0;
    localparam logic [NW-1:0]  ROOT   = NW'(1);

    rfct_pkg::walk_state_t state_reg, state_next;
    logic [NW-1:0]  n_reg, n_next;
    logic [DPW-1:0] d_reg, d_next;
    logic [L:0]     par_reg, par_next;
    logic [ACW-1:0] acc_reg, acc_next;
    logic [NW-1:0]  clr_reg, clr_next;
    logic [IW-1:0]  s_reg, s_next, e_reg, e_next;
    logic           func_reg, func_next;
    logic [CW-1:0]  lcnt_reg, lcnt_next, rcnt_reg, rcnt_next;

    logic [IW-1:0]  s_in, e_in, lo, hi;
    logic [NW-1:0]  offs;
    logic [DPW-1:0] sh;
    logic [CW-1:0]  size, cnt, sum;
    logic           mark, disjoint, covered;

    assign mark = mem_rdata[CW];
    assign cnt  = mem_rdata[CW-1:0];

    // Span of the current node from its heap index and depth.
    always_comb begin
        offs = n_reg ^ (ROOT << d_reg);
        sh   = DPW'(L) - d_reg;
        lo   = IW'(offs) << sh;
        hi   = lo + ((IW'(1) << sh) - IW'(1));
        size = CW'(1) << sh;
        sum  = lcnt_reg + rcnt_reg;
        disjoint = (e_reg < lo) || (hi < s_reg);
        covered  = (s_reg <= lo) && (hi <= e_reg);
        s_in = IW'(range_start);
        e_in = (IW'(range_end) > LAST) ? LAST : IW'(range_end);
    end

    assign idle = (state_reg == rfct_pkg::ST_IDLE);
    assign res.valid = (state_reg == rfct_pkg::ST_DONE);
    assign res.count = acc_reg[rfct_pkg::COUNT_W-1:0];

    always_comb begin
        state_next = state_reg;
        n_next     = n_reg;
        d_next     = d_reg;
        par_next   = par_reg;
        acc_next   = acc_reg;
        clr_next   = clr_reg;
        s_next     = s_reg;
        e_next     = e_reg;
        func_next  = func_reg;
        lcnt_next  = lcnt_reg;
        rcnt_next  = rcnt_reg;
        mem_we     = 1'b0;
        mem_waddr  = n_reg;
        mem_wdata  = '0;
        mem_raddr  = n_reg;
        unique case (state_reg)
            rfct_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                clr_next  = clr_reg + NW'(1);
                if (&clr_reg) begin
                    state_next = rfct_pkg::ST_IDLE;
                end
            end
            rfct_pkg::ST_IDLE: begin
                if (start) begin
                    s_next    = s_in;
                    e_next    = e_in;
                    func_next = func;
                    acc_next  = '0;
                    n_next    = ROOT;
                    d_next    = DEPTH0;
                    par_next  = '0;
                    if (s_in > e_in) begin
                        state_next = (func == rfct_pkg::FUNC_COUNT) ? rfct_pkg::ST_DONE
                                                                    : rfct_pkg::ST_IDLE;
                    end else begin
                        state_next = rfct_pkg::ST_RD;
                    end
                end
            end
            rfct_pkg::ST_RD: begin
                state_next = rfct_pkg::ST_CHK;
            end
            rfct_pkg::ST_CHK: begin
                priority if (disjoint) begin
                    state_next = rfct_pkg::ST_RET;
                end else if (covered) begin
                    if (func_reg == rfct_pkg::FUNC_FLIP) begin
                        mem_we    = 1'b1;
                        mem_wdata = {~mark, size - cnt};
                    end else begin
                        acc_next = acc_reg + ACW'(par_reg[d_reg] ? size - cnt : cnt);
                    end
                    state_next = rfct_pkg::ST_RET;
                end else begin
                    // Partial overlap: descend left, carrying the flip parity above.
                    par_next[d_reg + DPW'(1)] = par_reg[d_reg] ^ mark;
                    n_next     = n_reg << 1;
                    d_next     = d_reg + DPW'(1);
                    state_next = rfct_pkg::ST_RD;
                end
            end
            rfct_pkg::ST_RET: begin
                priority if (d_reg == DEPTH0) begin
                    state_next = (func_reg == rfct_pkg::FUNC_COUNT) ? rfct_pkg::ST_DONE
                                                                    : rfct_pkg::ST_IDLE;
                end else if (!n_reg[0]) begin
                    n_next     = n_reg + NW'(1);
                    state_next = rfct_pkg::ST_RD;
                end else begin
                    n_next     = n_reg >> 1;
                    d_next     = d_reg - DPW'(1);
                    state_next = (func_reg == rfct_pkg::FUNC_FLIP) ? rfct_pkg::ST_PL
                                                                   : rfct_pkg::ST_RET;
                end
            end
            rfct_pkg::ST_PL: begin
                mem_raddr  = n_reg << 1;
                state_next = rfct_pkg::ST_PR;
            end
            rfct_pkg::ST_PR: begin
                mem_raddr  = (n_reg << 1) | NW'(1);
                lcnt_next  = cnt;
                state_next = rfct_pkg::ST_PP;
            end
            rfct_pkg::ST_PP: begin
                rcnt_next  = cnt;
                state_next = rfct_pkg::ST_PW;
            end
            rfct_pkg::ST_PW: begin
                // A node's own mark inverts the sum of its children.
                mem_we     = 1'b1;
                mem_wdata  = {mark, mark ? size - sum : sum};
                state_next = rfct_pkg::ST_RET;
            end
            rfct_pkg::ST_DONE: begin
                if (res_ready) begin
                    state_next = rfct_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rfct_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rfct_pkg::ST_CLEAR;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
        end
    end

    always_ff @(posedge aclk) begin
        n_reg    <= n_next;
        d_reg    <= d_next;
        par_reg  <= par_next;
        acc_reg  <= acc_next;
        s_reg    <= s_next;
        e_reg    <= e_next;
        func_reg <= func_next;
        lcnt_reg <= lcnt_next;
        rcnt_reg <= rcnt_next;
    end

endmodule

// ===== hw/rtl/range_flip_count_tree_top.sv =====
// Each node visited passes through the read, check and return states; on a flip, each partly
// covered node is then rebuilt from its children in the PL, PR, PP and PW states.
// Throughput: one item at a time; a new item is taken when the walk has ended.
// The walk is bound by the single read port of the node store.
// Reset: synchronous, active low; then a clearing pass zeroes every entry of the node store,
// during which no item is accepted.
module range_flip_count_tree_top #(
    parameter int unsigned LEAVES = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_func,
    input  logic [rfct_pkg::IDX_W-1:0]         s_range_start,
    input  logic [rfct_pkg::IDX_W-1:0]         s_range_end,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [rfct_pkg::COUNT_W-1:0]       m_ones_count
);

    localparam int unsigned L  = $clog2(LEAVES);
    localparam int unsigned AW = L + 1;
    localparam int unsigned MW = L + 2;

    rfct_pkg::res_t res;
    logic           res_ready, idle;
    logic           mem_we;
    logic [AW-1:0]  mem_waddr, mem_raddr;
    logic [MW-1:0]  mem_wdata, mem_rdata;
    logic           m_valid_reg, m_valid_next;
    logic [rfct_pkg::COUNT_W-1:0] count_reg, count_next;

    assign s_ready      = idle;
    assign res_ready    = !m_valid_reg || m_ready;
    assign m_valid      = m_valid_reg;
    assign m_ones_count = count_reg;

    rfct_mem #(.AW(AW), .DW(MW)) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rfct_walk #(.LEAVES(LEAVES)) u_walk (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (s_valid && idle),
        .idle        (idle),
        .func        (s_func),
        .range_start (s_range_start),
        .range_end   (s_range_end),
        .res         (res),
        .res_ready   (res_ready),
        .mem_we      (mem_we),
        .mem_waddr   (mem_waddr),
        .mem_wdata   (mem_wdata),
        .mem_raddr   (mem_raddr),
        .mem_rdata   (mem_rdata)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        count_next   = count_reg;
        if (res.valid && res_ready) begin
            m_valid_next = 1'b1;
            count_next   = res.count;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        count_reg <= count_next;
    end

endmodule
